[rtl/assert_macros.svh]
// Assertion macros for the RTL of the coordinate validator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on clk, held off while rst_n is low.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent check on clk that stays live during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/dcv_pkg.sv]
// Package for the coordinate validator: state and result types, limits, character codes and the hemisphere check.
package dcv_pkg;

    localparam int unsigned ACC_W = 10;
    localparam int unsigned POS_W = 4;

    localparam logic [ACC_W-1:0] LAT_MAX_DEG = 10'd89;
    localparam logic [ACC_W-1:0] LON_MAX_DEG = 10'd179;
    localparam logic [ACC_W-1:0] MAX_MIN     = 10'd59;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_BLANK = 8'h20;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_UP_N  = 8'h4E;
    localparam logic [7:0] CH_LO_N  = 8'h6E;
    localparam logic [7:0] CH_UP_S  = 8'h53;
    localparam logic [7:0] CH_LO_S  = 8'h73;
    localparam logic [7:0] CH_UP_E  = 8'h45;
    localparam logic [7:0] CH_LO_E  = 8'h65;
    localparam logic [7:0] CH_UP_W  = 8'h57;
    localparam logic [7:0] CH_LO_W  = 8'h77;

    localparam logic [POS_W-1:0] LAST_POS_LON = 4'd8;

    typedef struct packed {
        logic             active;
        logic             lon;
        logic [POS_W-1:0] pos;
        logic             blank;
        logic [ACC_W-1:0] acc;
        logic             failed;
    } dcv_state_t;

    typedef struct packed {
        logic valid;
        logic field_ok;
        logic was_longitude;
    } dcv_result_t;

    function automatic logic hemisphere_ok(input logic [7:0] c, input logic lon);
        logic ok;
        if (lon)
        begin
            ok = (c == CH_UP_E) || (c == CH_LO_E) || (c == CH_UP_W) || (c == CH_LO_W);
        end
        else
        begin
            ok = (c == CH_UP_N) || (c == CH_LO_N) || (c == CH_UP_S) || (c == CH_LO_S);
        end
        return ok;
    endfunction

endpackage

[rtl/dcv_step.sv]
// Per-character check: next field state and result for one character.
module dcv_step
    import dcv_pkg::*;
(
    input  dcv_state_t  cur,
    input  logic [7:0]  ch,
    input  logic        start_req,
    input  logic        is_longitude,
    output dcv_state_t  nxt,
    output dcv_result_t res
);

    dcv_state_t       st;
    logic [POS_W-1:0] deg_len;
    logic [POS_W-1:0] min_end;
    logic [POS_W-1:0] dot_pos;
    logic [POS_W-1:0] hund_start;
    logic [POS_W-1:0] hemi_pos;
    logic             is_digit;
    logic             is_blank;
    logic [3:0]       digit;
    logic [ACC_W-1:0] acc_base;
    logic [ACC_W+3:0] acc_x10;
    logic [ACC_W-1:0] acc_new;
    logic [ACC_W-1:0] deg_max;

    always_comb
    begin
        st = cur;
        if (start_req)
        begin
            st.active = 1'b1;
            st.lon    = is_longitude;
            st.pos    = '0;
            st.blank  = 1'b0;
            st.acc    = '0;
            st.failed = 1'b0;
        end

        deg_len    = st.lon ? 4'd3 : 4'd2;
        min_end    = deg_len + 4'd1;
        dot_pos    = deg_len + 4'd2;
        hund_start = deg_len + 4'd3;
        hemi_pos   = deg_len + 4'd5;
        deg_max    = st.lon ? LON_MAX_DEG : LAT_MAX_DEG;

        is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
        is_blank = (ch == CH_BLANK);
        digit    = 4'(ch - CH_ZERO);

        acc_base = ((st.pos == '0) || (st.pos == deg_len) || (st.pos == hund_start))
                   ? '0 : st.acc;
        acc_x10  = ({4'b0, acc_base} << 3) + ({4'b0, acc_base} << 1);

        nxt = st;
        res = '{valid: 1'b0, field_ok: 1'b0, was_longitude: st.lon};
        acc_new = acc_base;

        if (st.active)
        begin
            if (st.pos >= hemi_pos)
            begin
                res.valid    = 1'b1;
                res.field_ok = !st.failed && hemisphere_ok(ch, st.lon);
                nxt.failed   = !res.field_ok;
                nxt.active   = 1'b0;
                nxt.pos      = '0;
            end
            else
            begin
                if (st.pos == dot_pos)
                begin
                    if (!st.blank && ch == CH_DOT)
                    begin
                        nxt.failed = st.failed;
                    end
                    else if (!st.blank && is_blank)
                    begin
                        nxt.blank = 1'b1;
                    end
                    else
                    begin
                        nxt.failed = 1'b1;
                    end
                end
                else
                begin
                    if (is_digit && !st.blank)
                    begin
                        acc_new = ACC_W'(acc_x10 + {10'b0, digit});
                    end
                    else if (is_blank)
                    begin
                        acc_new   = ACC_W'(acc_x10);
                        nxt.blank = 1'b1;
                    end
                    else
                    begin
                        nxt.failed = 1'b1;
                    end
                    nxt.acc = acc_new;
                    if ((st.pos == deg_len - 4'd1) && (acc_new > deg_max))
                    begin
                        nxt.failed = 1'b1;
                    end
                    if ((st.pos == min_end) && (acc_new > MAX_MIN))
                    begin
                        nxt.failed = 1'b1;
                    end
                end
                nxt.pos = st.pos + 4'd1;
            end
        end
    end

endmodule

[rtl/degmin_coordinate_validator_core.sv]
// Top level of the degrees-minutes coordinate validator.
//
//  channel | dir | tdata                      | tuser
//  s_*     | in  | ch[7:0]                    | start_req[0], is_longitude[1]
//  m_*     | out | field_ok[0], zeros [7:1]   | was_longitude[0]
//
//  One character per cycle while m_tready does not stall the output; the final character
//  passes the input register and then the result register before its result word is on m_tdata.
//  Field state advances when a character leaves the input register, which
//  needs room in the result register; only the final character writes it.
//  rst_n clears the valid flags and the field state at once.
//  A stalled m_tready holds the result and stops the input after one word.
module degmin_coordinate_validator_core
    import dcv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // ch[7:0]
    input  logic [1:0] s_tuser,   // start_req[0], is_longitude[1]
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // field_ok[0], zero fill [7:1]
    output logic [0:0] m_tuser    // was_longitude[0]
);

`include "assert_macros.svh"

    logic        in_valid_reg;
    logic [7:0]  ch_reg;
    logic [1:0]  user_reg;
    logic        out_valid_reg;
    logic        field_ok_reg;
    logic        was_lon_reg;
    dcv_state_t  state_reg;
    dcv_state_t  state_next;
    dcv_result_t step_res;
    logic        adv;

    assign adv      = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || adv;

    dcv_step u_step (
        .cur          (state_reg),
        .ch           (ch_reg),
        .start_req    (user_reg[0]),
        .is_longitude (user_reg[1]),
        .nxt          (state_next),
        .res          (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (adv)
            begin
                state_reg <= state_next;
            end
            if (adv && step_res.valid)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            ch_reg   <= s_tdata;
            user_reg <= s_tuser;
        end
        if (adv && step_res.valid)
        begin
            field_ok_reg <= step_res.field_ok;
            was_lon_reg  <= step_res.was_longitude;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, field_ok_reg};
    assign m_tuser  = was_lon_reg;

    `ASSERT_CLK(a_pos_in_range, state_reg.pos <= LAST_POS_LON, "field position past last char")
    `ASSERT_CLK(a_idle_pos_zero, !state_reg.active |-> state_reg.pos == '0,
                "idle with nonzero position")
    `ASSERT_CLK(a_result_from_step, $rose(m_tvalid) |-> $past(adv),
                "result word without a processed character")
    `ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !m_tvalid && !state_reg.active,
                   "not idle after reset")

endmodule
